// File: sv/md5_pkg.sv
package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    // datapath commands
    typedef struct packed {
        logic       put_byte;    // write byte at fill position
        logic [7:0] byte_val;
        logic       put_len;     // write length words 14, 15
        logic       len_add;     // count 8 message bits
        logic       fill_inc;    // advance fill position
        logic       round_start; // load working regs from chain
        logic       round_step;  // one round
        logic       round_done;  // add working regs into chain
        logic       restart;     // back to initial values
        logic [5:0] round_idx;
    } md5_cmd_t;

    typedef struct packed {
        logic [5:0] fill_pos;
    } md5_stat_t;

    function automatic logic [31:0] md5_k(input logic [5:0] r);
        logic [31:0] k;
        begin
            unique case (r)
                6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
                6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
                6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
                6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
                6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] md5_s(input logic [3:0] i);
        logic [4:0] s;
        begin
            unique case (i)
                4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
                4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
                4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
                4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
            endcase
            return s;
        end
    endfunction

endpackage

// File: sv/md5_hash_engine.sv
// channel | ports        | tdata                          | tuser / tlast
// s_axis  | s_axis_t*    | [7:0] msg_byte                 | tuser byte_present, tlast end
// m_axis  | m_axis_t*    | [31:0] digest_word,[33:32] num | tlast final_word
//
// a byte item leaves the input ready for the next; a byte that fills the block adds a compression
// (start, 64 rounds on one shared round unit, chain add)
// a closing item pads one byte per cycle, pausing while a filled block is compressed,
// then writes the length words and compresses the last block
// the four digest items hold until taken; input is stalled meanwhile
// aresetn is synchronous active low and loads the initial chain values
module md5_hash_engine
    import md5_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] msg_byte
    input  logic        s_axis_tuser,  // [0] byte_present
    input  logic        s_axis_tlast,  // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [31:0] digest_word, [33:32] word_number
    output logic        m_axis_tlast   // final_word
);

    md5_cmd_t    cmd;
    md5_stat_t   stat;
    logic [31:0] ca, cb, cc, cd;
    logic [1:0]  wn;
    logic [31:0] word;

    md5_ctrl u_ctrl (
        .aclk, .aresetn, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .s_axis_tuser, .s_axis_tlast, .m_axis_tvalid, .m_axis_tready,
        .m_word_num(wn), .stat, .cmd
    );

    md5_datapath u_dp (
        .aclk, .aresetn, .cmd, .stat,
        .chain_a(ca), .chain_b(cb), .chain_c(cc), .chain_d(cd)
    );

    // pick the digest word for the current output item
    always_comb begin
        unique case (wn)
            2'd0: word = ca;
            2'd1: word = cb;
            2'd2: word = cc;
            default: word = cd;
        endcase
    end

    assign m_axis_tdata = {6'd0, wn, word};
    assign m_axis_tlast = (wn == 2'd3);

endmodule

// File: sv/md5_datapath.sv
module md5_datapath
    import md5_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  md5_cmd_t    cmd,
    output md5_stat_t   stat,
    output logic [31:0] chain_a,
    output logic [31:0] chain_b,
    output logic [31:0] chain_c,
    output logic [31:0] chain_d
);

    logic [31:0] blk_reg [16];
    logic [31:0] ca_reg, cb_reg, cc_reg, cd_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [63:0] len_reg;
    logic [5:0]  fill_reg;

    logic [1:0]  stage;
    logic [3:0]  g;
    logic [31:0] f, t, rot;
    logic [4:0]  sh;
    logic [5:0]  r;

    assign r     = cmd.round_idx;
    assign stage = r[5:4];

    always_comb begin
        unique case (stage)
            2'd0: begin
                f = (b_reg & c_reg) | (~b_reg & d_reg);
                g = r[3:0];
            end
            2'd1: begin
                f = (b_reg & d_reg) | (c_reg & ~d_reg);
                g = 4'(5 * r[3:0] + 1);
            end
            2'd2: begin
                f = b_reg ^ c_reg ^ d_reg;
                g = 4'(3 * r[3:0] + 5);
            end
            default: begin
                f = c_reg ^ (b_reg | ~d_reg);
                g = 4'(7 * r[3:0]);
            end
        endcase
        sh  = md5_s({stage, r[1:0]});
        t   = a_reg + f + blk_reg[g] + md5_k(r);
        rot = (t << sh) | (t >> (6'd32 - {1'b0, sh}));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ca_reg   <= IV_A;
            cb_reg   <= IV_B;
            cc_reg   <= IV_C;
            cd_reg   <= IV_D;
            len_reg  <= '0;
            fill_reg <= '0;
        end else begin
            if (cmd.put_byte) begin
                if (fill_reg[1:0] == 2'd0)
                    blk_reg[fill_reg[5:2]] <= {24'd0, cmd.byte_val};
                else
                    blk_reg[fill_reg[5:2]][{fill_reg[1:0], 3'd0} +: 8] <= cmd.byte_val;
            end
            if (cmd.put_len) begin
                blk_reg[14] <= len_reg[31:0];
                blk_reg[15] <= len_reg[63:32];
            end
            if (cmd.len_add) len_reg <= len_reg + 64'd8;
            if (cmd.fill_inc) fill_reg <= fill_reg + 6'd1;
            if (cmd.round_start) begin
                a_reg <= ca_reg; b_reg <= cb_reg; c_reg <= cc_reg; d_reg <= cd_reg;
            end
            if (cmd.round_step) begin
                a_reg <= d_reg;
                d_reg <= c_reg;
                c_reg <= b_reg;
                b_reg <= rot + b_reg;
            end
            if (cmd.round_done) begin
                ca_reg <= ca_reg + a_reg;
                cb_reg <= cb_reg + b_reg;
                cc_reg <= cc_reg + c_reg;
                cd_reg <= cd_reg + d_reg;
            end
            if (cmd.restart) begin
                ca_reg   <= IV_A;
                cb_reg   <= IV_B;
                cc_reg   <= IV_C;
                cd_reg   <= IV_D;
                len_reg  <= '0;
                fill_reg <= '0;
            end
        end
    end

    assign stat.fill_pos = fill_reg;
    assign chain_a = ca_reg;
    assign chain_b = cb_reg;
    assign chain_c = cc_reg;
    assign chain_d = cd_reg;

endmodule

// File: sv/md5_ctrl.sv
module md5_ctrl
    import md5_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [1:0]  m_word_num,
    input  md5_stat_t   stat,
    output md5_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_DONE  = 3'd3;
    localparam logic [2:0] ST_PAD   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [5:0] rnd_reg, rnd_next;
    logic       fin_reg, fin_next;     // compression is the closing one
    logic       pad_reg, pad_next;     // 0x80 already placed
    logic       close_reg, close_next; // close pending after a full block
    logic [1:0] wn_reg, wn_next;
    logic       acc;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign acc = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_word_num = wn_reg;

    always_comb begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        fin_next   = fin_reg;
        pad_next   = pad_reg;
        close_next = close_reg;
        wn_next    = wn_reg;
        cmd        = '0;
        cmd.round_idx = rnd_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    pad_next = 1'b0;
                    fin_next = 1'b0;
                    close_next = s_axis_tlast;
                    if (s_axis_tuser) begin
                        cmd.put_byte = 1'b1;
                        cmd.byte_val = s_axis_tdata;
                        cmd.len_add  = 1'b1;
                        cmd.fill_inc = 1'b1;
                        if (stat.fill_pos == 6'd63) state_next = ST_START;
                        else if (s_axis_tlast) state_next = ST_PAD;
                    end else if (s_axis_tlast) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                // one padding byte per cycle, or the length words once 0x80 is placed and position 56 is reached
                if (stat.fill_pos == 6'd56 && pad_reg) begin
                    cmd.put_len = 1'b1;
                    cmd.fill_inc = 1'b0;
                    fin_next = 1'b1;
                    state_next = ST_START;
                end else begin
                    cmd.put_byte = 1'b1;
                    cmd.byte_val = pad_reg ? 8'h00 : 8'h80;
                    cmd.fill_inc = 1'b1;
                    pad_next = 1'b1;
                    if (stat.fill_pos == 6'd63) state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.round_start = 1'b1;
                rnd_next = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round_step = 1'b1;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) state_next = ST_DONE;
            end
            ST_DONE: begin
                cmd.round_done = 1'b1;
                wn_next = '0;
                if (fin_reg) state_next = ST_OUT;
                else if (close_reg) state_next = ST_PAD;
                else state_next = ST_IDLE;
            end
            ST_OUT: begin
                if (m_axis_tready) begin
                    wn_next = wn_reg + 2'd1;
                    if (wn_reg == 2'd3) begin
                        cmd.restart = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
            fin_reg   <= 1'b0;
            pad_reg   <= 1'b0;
            close_reg <= 1'b0;
            wn_reg    <= '0;
        end else begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            fin_reg   <= fin_next;
            pad_reg   <= pad_next;
            close_reg <= close_next;
            wn_reg    <= wn_next;
        end
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND) |-> !s_axis_tready)
        else $error("input taken during rounds");
    a_round_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && rnd_reg == 6'd63) |=> (state_reg == ST_DONE))
        else $error("round count lost");
    a_out_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tready && wn_reg == 2'd3) |=> (state_reg == ST_IDLE))
        else $error("digest end lost");

endmodule
